[rtl/nnhl_pkg.sv]
// Shared constants, codes and the name folding function of the name lookup table.
`default_nettype none
package nnhl_pkg;
  localparam int KIND_COUNT = 5;
  localparam int REG_COUNT = 6;
  localparam int REG_W = 11;
  localparam int MAX_NAME_LEN = 32;
  localparam int BUCKET_AW = 10;
  localparam int NAME_AW = 13;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_LEN = 2'd1;
  localparam logic [1:0] MODE_PLACE = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PLACED = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef logic [REG_W-1:0] reg_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_DASH) r = CH_UNDER;
    else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) r = c - CH_UPPER_A + CH_LOWER_A;
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/nnhl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module nnhl_ram #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/nnhl_hash.sv]
// One FNV-1a step over a folded byte; the prime multiply is done as shifts and adds.
`default_nettype none
module nnhl_hash (
  input  wire logic [63:0] hash_in,
  input  wire logic [7:0]  data,
  output logic      [63:0] hash_out
);
  logic [63:0] x;

  // The prime is 2^40 + 0x1B3.
  always_comb begin
    x = hash_in ^ {56'd0, nnhl_pkg::fold(data)};
    hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  end
endmodule
`default_nettype wire

[rtl/normalized_name_hash_lookup_top.sv]
// Name lookup table: stored names are placed into per-kind bucket regions by FNV-1a
// hash with triangular probing, and streamed lookup names are matched case-folded.
// After reset all 1024 buckets of the bucket table are swept clear with s_tready low.
// Name byte, length and non-final lookup byte requests complete on acceptance. A place
// request hashes its L stored name bytes through the one hash unit, then makes P
// probes with one bucket RAM read each; a final lookup byte makes P probes, and for
// every occupied bucket it fetches the stored length, and when that length matches
// it compares the bytes one at a time out of the name store RAM.
`default_nettype none
module normalized_name_hash_lookup_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] entry, [12:8] position, [20:13] name_byte, [26:21] name_length, rest zero
  input  wire logic [31:0] s_tdata,
  // [1:0] mode, [4:2] kind, [5] empty_name
  input  wire logic [5:0]  s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] index
  output logic [7:0]       m_tdata,
  // [1:0] status
  output logic [1:0]       m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LK_EVAL = 4'd2;
  localparam logic [3:0] S_PL_LEN = 4'd3;
  localparam logic [3:0] S_PL_RD = 4'd4;
  localparam logic [3:0] S_PL_HS = 4'd5;
  localparam logic [3:0] S_PR_INIT = 4'd6;
  localparam logic [3:0] S_PR_RD = 4'd7;
  localparam logic [3:0] S_PR_CHK = 4'd8;
  localparam logic [3:0] S_MT_LEN = 4'd9;
  localparam logic [3:0] S_MT_RD = 4'd10;
  localparam logic [3:0] S_MT_CMP = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state;
  nnhl_pkg::reg_t cfg_regs [nnhl_pkg::REG_COUNT];

  logic [1:0] in_mode;
  logic [2:0] in_kind;
  logic [7:0] in_entry;
  logic [4:0] in_pos;
  logic [7:0] in_byte;
  logic [5:0] in_len;
  logic       in_empty;
  logic       accept;

  assign in_mode = s_tuser[1:0];
  assign in_kind = s_tuser[4:2];
  assign in_empty = s_tuser[5];
  assign in_entry = s_tdata[7:0];
  assign in_pos = s_tdata[12:8];
  assign in_byte = s_tdata[20:13];
  assign in_len = s_tdata[26:21];
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;

  // Region of the requested kind.
  logic           kind_ok;
  nnhl_pkg::reg_t reg_start;
  nnhl_pkg::reg_t reg_end;
  nnhl_pkg::reg_t reg_size;
  always_comb begin
    kind_ok = (in_kind < 3'(nnhl_pkg::KIND_COUNT));
    reg_start = kind_ok ? cfg_regs[in_kind] : '0;
    reg_end = kind_ok ? cfg_regs[3'(in_kind + 3'd1)] : '0;
    reg_size = reg_end - reg_start;
  end

  logic           op_lookup;
  logic           region_ok;
  nnhl_pkg::reg_t start_r;
  nnhl_pkg::reg_t size_r;
  nnhl_pkg::reg_t mask_r;
  nnhl_pkg::reg_t slot;
  nnhl_pkg::reg_t step;
  nnhl_pkg::reg_t probes;
  logic [9:0]     addr_r;
  logic [7:0]     entry_r;
  logic [5:0]     len_r;
  logic [5:0]     idx;
  logic [63:0]    phash;
  logic [63:0]    lhash;
  logic [5:0]     lcount;
  logic           too_long;
  logic [9:0]     clr_addr;
  logic [1:0]     res_status;
  logic [7:0]     res_index;

  // Shared hash step.
  logic [63:0] hash_in;
  logic [7:0]  hash_data;
  logic [63:0] hash_out;
  logic [7:0]  name_q;
  assign hash_in = (state == S_PL_HS) ? phash : lhash;
  assign hash_data = (state == S_PL_HS) ? name_q : in_byte;
  nnhl_hash u_hash (.hash_in(hash_in), .data(hash_data), .hash_out(hash_out));

  // Name store.
  logic                          name_we;
  logic [nnhl_pkg::NAME_AW-1:0]  name_raddr;
  assign name_we = accept && (in_mode == nnhl_pkg::MODE_BYTE);
  assign name_raddr = {entry_r, idx[4:0]};
  nnhl_ram #(.AW(nnhl_pkg::NAME_AW), .DW(8)) u_names (
    .clk(clk), .we(name_we), .waddr({in_entry, in_pos}), .wdata(in_byte),
    .raddr(name_raddr), .rdata(name_q)
  );

  // Name lengths, saturated on write.
  logic       len_we;
  logic [5:0] len_wdata;
  logic [7:0] len_raddr;
  logic [5:0] len_q;
  logic [8:0] bucket_q;
  assign len_we = accept && (in_mode == nnhl_pkg::MODE_LEN);
  assign len_wdata = (in_len > 6'(nnhl_pkg::MAX_NAME_LEN)) ?
                     6'(nnhl_pkg::MAX_NAME_LEN) : in_len;
  assign len_raddr = (state == S_PR_CHK) ? bucket_q[7:0] : in_entry;
  nnhl_ram #(.AW(8), .DW(6)) u_lens (
    .clk(clk), .we(len_we), .waddr(in_entry), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_q)
  );

  // Lookup name buffer.
  logic       add_byte;
  logic       buf_we;
  logic [7:0] buf_q;
  assign add_byte = accept && (in_mode == nnhl_pkg::MODE_LOOKUP) && !(s_tlast && in_empty);
  assign buf_we = add_byte && (lcount < 6'(nnhl_pkg::MAX_NAME_LEN));
  nnhl_ram #(.AW(5), .DW(8)) u_buf (
    .clk(clk), .we(buf_we), .waddr(lcount[4:0]), .wdata(in_byte),
    .raddr(idx[4:0]), .rdata(buf_q)
  );

  // Bucket table: bit 8 marks a valid bucket.
  logic                            bucket_we;
  logic [nnhl_pkg::BUCKET_AW-1:0]  bucket_waddr;
  logic [8:0]                      bucket_wdata;
  logic [nnhl_pkg::BUCKET_AW-1:0]  bucket_raddr;
  nnhl_pkg::reg_t                  probe_sum;
  logic                            place_hit;
  assign place_hit = (state == S_PR_CHK) && !op_lookup && !bucket_q[8];
  assign bucket_we = (state == S_CLR) || place_hit;
  assign bucket_waddr = (state == S_CLR) ? clr_addr : addr_r;
  assign bucket_wdata = (state == S_CLR) ? 9'd0 : {1'b1, entry_r};
  assign probe_sum = start_r + slot;
  assign bucket_raddr = probe_sum[nnhl_pkg::BUCKET_AW-1:0];
  nnhl_ram #(.AW(nnhl_pkg::BUCKET_AW), .DW(9)) u_buckets (
    .clk(clk), .we(bucket_we), .waddr(bucket_waddr), .wdata(bucket_wdata),
    .raddr(bucket_raddr), .rdata(bucket_q)
  );

  nnhl_pkg::reg_t slot_adv;
  assign slot_adv = (slot + step) & mask_r;

  logic fold_eq;
  assign fold_eq = (nnhl_pkg::fold(name_q) == nnhl_pkg::fold(buf_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      for (int i = 0; i < nnhl_pkg::REG_COUNT; i++) cfg_regs[i] <= '0;
      lhash <= nnhl_pkg::FNV_BASIS;
      lcount <= '0;
      too_long <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < 3'(nnhl_pkg::REG_COUNT)) cfg_regs[cfg_index] <= cfg_data;
      // The result state reloads the output itself when the old result leaves.
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 10'd1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            start_r <= reg_start;
            size_r <= reg_size;
            mask_r <= reg_size - 11'd1;
            region_ok <= kind_ok && (reg_size != '0);
            entry_r <= in_entry;
            if (add_byte) begin
              lhash <= hash_out;
              if (buf_we) lcount <= lcount + 6'd1;
              else too_long <= 1'b1;
            end
            if (in_mode == nnhl_pkg::MODE_PLACE) begin
              op_lookup <= 1'b0;
              phash <= nnhl_pkg::FNV_BASIS;
              idx <= '0;
              if (kind_ok && (reg_size != '0)) begin
                state <= S_PL_LEN;
              end else begin
                res_status <= nnhl_pkg::ST_FULL;
                res_index <= '0;
                state <= S_DONE;
              end
            end else if (in_mode == nnhl_pkg::MODE_LOOKUP && s_tlast) begin
              op_lookup <= 1'b1;
              state <= S_LK_EVAL;
            end
          end
        end
        S_LK_EVAL: begin
          if (too_long || !region_ok) begin
            res_status <= nnhl_pkg::ST_NOT_FOUND;
            res_index <= '0;
            state <= S_DONE;
          end else begin
            state <= S_PR_INIT;
          end
        end
        S_PL_LEN: begin
          len_r <= len_q;
          state <= (len_q == '0) ? S_PR_INIT : S_PL_RD;
        end
        S_PL_RD: state <= S_PL_HS;
        S_PL_HS: begin
          phash <= hash_out;
          idx <= idx + 6'd1;
          state <= (idx + 6'd1 == len_r) ? S_PR_INIT : S_PL_RD;
        end
        S_PR_INIT: begin
          slot <= (op_lookup ? lhash[10:0] : phash[10:0]) & mask_r;
          step <= 11'd1;
          probes <= '0;
          state <= S_PR_RD;
        end
        S_PR_RD: begin
          if (probes == size_r) begin
            res_status <= op_lookup ? nnhl_pkg::ST_NOT_FOUND : nnhl_pkg::ST_FULL;
            res_index <= '0;
            state <= S_DONE;
          end else begin
            addr_r <= bucket_raddr;
            state <= S_PR_CHK;
          end
        end
        S_PR_CHK: begin
          if (!bucket_q[8]) begin
            res_status <= op_lookup ? nnhl_pkg::ST_NOT_FOUND : nnhl_pkg::ST_PLACED;
            res_index <= op_lookup ? 8'd0 : entry_r;
            state <= S_DONE;
          end else if (op_lookup) begin
            entry_r <= bucket_q[7:0];
            state <= S_MT_LEN;
          end else begin
            slot <= slot_adv;
            step <= step + 11'd1;
            probes <= probes + 11'd1;
            state <= S_PR_RD;
          end
        end
        S_MT_LEN: begin
          len_r <= len_q;
          idx <= '0;
          if (len_q != lcount) begin
            slot <= slot_adv;
            step <= step + 11'd1;
            probes <= probes + 11'd1;
            state <= S_PR_RD;
          end else if (len_q == '0) begin
            res_status <= nnhl_pkg::ST_FOUND;
            res_index <= entry_r;
            state <= S_DONE;
          end else begin
            state <= S_MT_RD;
          end
        end
        S_MT_RD: state <= S_MT_CMP;
        S_MT_CMP: begin
          if (!fold_eq) begin
            slot <= slot_adv;
            step <= step + 11'd1;
            probes <= probes + 11'd1;
            state <= S_PR_RD;
          end else if (idx + 6'd1 == len_r) begin
            res_status <= nnhl_pkg::ST_FOUND;
            res_index <= entry_r;
            state <= S_DONE;
          end else begin
            idx <= idx + 6'd1;
            state <= S_MT_RD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser <= res_status;
            m_tdata <= res_index;
            if (op_lookup) begin
              lhash <= nnhl_pkg::FNV_BASIS;
              lcount <= '0;
              too_long <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A bucket claimed by a placement is reported as placed on the next cycle.
  a_place_reports: assert property (@(posedge clk) disable iff (rst)
    place_hit |=> (state == S_DONE) && (res_status == nnhl_pkg::ST_PLACED))
    else $error("bucket written without a placed result");

  // The probe count never runs past the region size.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PR_CHK) |-> (probes < size_r))
    else $error("probe count exceeded region size");

  // A new result only appears out of the result state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the result state");

  // The lookup buffer count never exceeds the name limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MT_CMP) |-> (idx < lcount) && (lcount <= 6'(nnhl_pkg::MAX_NAME_LEN)))
    else $error("name compare past the buffered name");
endmodule
`default_nettype wire
